FILE: design/i2s_pcm_frame_deserializer_unit_assert.svh
// assertion macros for the checker file
`ifndef I2S_PCM_FRAME_DESERIALIZER_UNIT_ASSERT_SVH
`define I2S_PCM_FRAME_DESERIALIZER_UNIT_ASSERT_SVH

// clocked assertion, off while reset is high
`define I2SD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define I2SD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/i2sd_pkg.sv
`default_nettype none
package i2sd_pkg;

  localparam int MAX_FRAME_BITS_DEF = 256;
  localparam int WORD_W = 64;
  localparam int POS_W = 6;
  localparam int WB_W = 7;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    KIND_CH_ONE   = 3'd0,
    KIND_CH_TWO   = 3'd1,
    KIND_UNEVEN   = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_FRAME_LAYOUT  = 3'd0,
    REG_WORD_BITS     = 3'd1,
    REG_RIGHT_ALIGNED = 3'd2,
    REG_LSB_FIRST     = 3'd3,
    REG_WS_INVERTED   = 3'd4,
    REG_SIGNED_WORDS  = 3'd5,
    REG_ONE_BIT_DELAY = 3'd6
  } reg_idx_t;

  localparam logic [1:0] LAYOUT_ONE = 2'd0;
  localparam logic [1:0] LAYOUT_TWO = 2'd1;

  typedef struct packed {
    logic             clear;
    logic             issue;
    logic [POS_W-1:0] pos;
  } word_ctrl_t;

  function automatic logic [WB_W-1:0] eff_word_bits(input logic [WB_W-1:0] w);
    logic [WB_W-1:0] r;
    if (w == '0) begin
      r = WB_W'(1);
    end else if (w > WB_W'(WORD_W)) begin
      r = WB_W'(WORD_W);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/i2sd_frame_mem.sv
`default_nettype none
module i2sd_frame_mem
  import i2sd_pkg::*;
#(
  parameter int DEPTH  = MAX_FRAME_BITS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic              wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic                   rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/i2sd_word_unit.sv
`default_nettype none
module i2sd_word_unit
  import i2sd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire word_ctrl_t        ctrl,
  input  wire logic              rd_bit,
  input  wire logic [WB_W-1:0]   wb_eff,
  input  wire logic              signed_words,
  output logic [WORD_W-1:0]      word
);

  logic              issue_d;
  logic [POS_W-1:0]  pos_d;
  logic [WORD_W-1:0] acc;
  logic [POS_W-1:0]  wb_m1;
  logic              ext;

  // read data arrives the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d <= 1'b0;
    end else begin
      issue_d <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    pos_d <= ctrl.pos;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (issue_d) begin
      acc[pos_d] <= rd_bit;
    end
  end

  assign wb_m1 = POS_W'(wb_eff - WB_W'(1));
  assign ext   = signed_words && (wb_eff != WB_W'(WORD_W)) && acc[wb_m1];
  assign word  = ext ? (acc | ({WORD_W{1'b1}} << wb_eff)) : acc;

endmodule
`default_nettype wire

FILE: design/i2s_pcm_frame_deserializer_unit.sv
// serial audio frame receiver
// s_* channel: one transfer per sampled bit-clock edge, s_tdata[0] is the data
//   line and s_tuser the word-select line
// m_* channel: decoded words, m_tuser holds kind and subframe, m_tlast marks the
//   final result of the input that closed a frame
// apb port: seven config registers at byte addresses 0..24, write only while idle
// an input that does not close a frame leaves the sequencer idle and s_tready
// stays high. a frame close runs a check step, then per subframe word_bits
// single-bit reads from the frame store, one drain step and one output step;
// an error close goes from check straight to output. the store has one read port.
// the output register lets the next bit be taken while a result waits, but a
// stalled m_tready holds the sequencer in its output step during a frame close
// reset: unlocked, waits for the first word-select rising edge, registers return
// to their defaults, m_tvalid drops
`default_nettype none
module i2s_pcm_frame_deserializer_unit
  import i2sd_pkg::*;
#(
  parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,  // [0] data_bit, rest zero
  input  wire logic                  s_tuser,  // [0] ws_bit
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [63:0]                m_tdata,  // [63:0] word_value
  output logic [4:0]                 m_tuser,  // [2:0] kind, [4:3] subframe
  output logic                       m_tlast,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int ADDR_W = $clog2(MAX_FRAME_BITS);
  localparam int CNT_W  = $clog2(MAX_FRAME_BITS + 1);
  localparam int CMP_W  = (CNT_W > WB_W) ? CNT_W : WB_W;

  // config registers
  logic [1:0]      frame_layout;
  logic [WB_W-1:0] word_bits;
  logic            right_aligned;
  logic            lsb_first;
  logic            ws_inverted;
  logic            signed_words;
  logic            one_bit_delay;
  logic            cfg_we;
  reg_idx_t        cfg_idx;

  // sequencer and frame state
  seq_state_t       state, state_next;
  logic [CNT_W-1:0] bit_count;
  logic             prev_ws;
  logic             locked;
  logic             overflowed;
  logic             pend_push;
  logic             pend_bit;
  logic [CNT_W-1:0] per;
  logic [CNT_W-1:0] base;
  logic [POS_W-1:0] j;
  logic [1:0]       sub;
  logic             err_mode;
  kind_t            err_kind;

  // output register
  logic [63:0] out_value;
  kind_t       out_kind;
  logic [1:0]  out_sub;
  logic        out_last;

  // combinational
  logic              in_acc;
  logic              din;
  logic              ws_edge;
  logic              push_en;
  logic              push_data;
  logic              restart;
  logic              emit_go;
  logic              store_full;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_rdata;
  word_ctrl_t        wctl;
  logic [WORD_W-1:0] word;
  logic [WB_W-1:0]   wb_eff;
  logic [POS_W-1:0]  wb_m1;
  logic [1:0]        part_shift;
  logic [1:0]        parts_m1;
  logic [CNT_W-1:0]  per_c;
  logic              uneven;
  logic              too_short;
  logic              chk_err;
  logic              last_sub;
  kind_t             chan_kind;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_FRAME_LAYOUT:  prdata = APB_DATA_W'(frame_layout);
      REG_WORD_BITS:     prdata = APB_DATA_W'(word_bits);
      REG_RIGHT_ALIGNED: prdata = APB_DATA_W'(right_aligned);
      REG_LSB_FIRST:     prdata = APB_DATA_W'(lsb_first);
      REG_WS_INVERTED:   prdata = APB_DATA_W'(ws_inverted);
      REG_SIGNED_WORDS:  prdata = APB_DATA_W'(signed_words);
      REG_ONE_BIT_DELAY: prdata = APB_DATA_W'(one_bit_delay);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_layout  <= 2'd0;
      word_bits     <= WB_W'(16);
      right_aligned <= 1'b0;
      lsb_first     <= 1'b0;
      ws_inverted   <= 1'b0;
      signed_words  <= 1'b1;
      one_bit_delay <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_LAYOUT:  frame_layout  <= pwdata[1:0];
        REG_WORD_BITS:     word_bits     <= pwdata[WB_W-1:0];
        REG_RIGHT_ALIGNED: right_aligned <= pwdata[0];
        REG_LSB_FIRST:     lsb_first     <= pwdata[0];
        REG_WS_INVERTED:   ws_inverted   <= pwdata[0];
        REG_SIGNED_WORDS:  signed_words  <= pwdata[0];
        REG_ONE_BIT_DELAY: one_bit_delay <= pwdata[0];
        default: ;
      endcase
    end
  end

  // frame split arithmetic
  assign wb_eff     = eff_word_bits(word_bits);
  assign wb_m1      = POS_W'(wb_eff - WB_W'(1));
  assign part_shift = (frame_layout == LAYOUT_ONE) ? 2'd0 :
                      (frame_layout == LAYOUT_TWO) ? 2'd1 : 2'd2;
  assign parts_m1   = (frame_layout == LAYOUT_ONE) ? 2'd0 :
                      (frame_layout == LAYOUT_TWO) ? 2'd1 : 2'd3;
  assign per_c      = bit_count >> part_shift;
  assign uneven     = (bit_count[1:0] & parts_m1) != 2'd0;
  assign too_short  = CMP_W'(per_c) < CMP_W'(wb_eff);
  assign chk_err    = overflowed | uneven | too_short;
  assign last_sub   = (sub == parts_m1);
  assign chan_kind  = (sub[0] == ~ws_inverted) ? KIND_CH_ONE : KIND_CH_TWO;

  assign din        = s_tdata[0];
  assign ws_edge    = s_tuser & ~prev_ws;
  assign in_acc     = s_tvalid & s_tready;
  assign store_full = (bit_count == CNT_W'(MAX_FRAME_BITS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && locked && ws_edge) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = chk_err ? ST_EMIT : ST_READ;
      ST_READ: begin
        if (j == wb_m1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_next = (err_mode || last_sub) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    push_en   = 1'b0;
    push_data = din;
    restart   = 1'b0;
    emit_go   = 1'b0;
    wctl      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!locked) begin
            if (ws_edge) begin
              restart = 1'b1;
              push_en = ~one_bit_delay;
            end
          end else if (!ws_edge || one_bit_delay) begin
            push_en = 1'b1;
          end
        end
      end
      ST_CHECK: wctl.clear = 1'b1;
      ST_READ: begin
        wctl.issue = 1'b1;
        wctl.pos   = lsb_first ? j : POS_W'(wb_m1 - j);
      end
      ST_DRAIN: ;
      ST_EMIT: begin
        emit_go = ~m_tvalid | m_tready;
        if (emit_go) begin
          if (err_mode || last_sub) begin
            // frame done, start the next one, with the held edge bit when one_bit_delay is off
            restart   = 1'b1;
            push_en   = pend_push;
            push_data = pend_bit;
          end else begin
            wctl.clear = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign mem_we    = push_en & (restart | ~store_full);
  assign mem_waddr = restart ? '0 : bit_count[ADDR_W-1:0];
  assign mem_raddr = ADDR_W'(base + CNT_W'(j));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bit_count  <= '0;
      prev_ws    <= 1'b1;
      locked     <= 1'b0;
      overflowed <= 1'b0;
      pend_push  <= 1'b0;
      err_mode   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        prev_ws <= s_tuser;
        if (ws_edge) begin
          locked <= 1'b1;
        end
      end
      if (restart) begin
        bit_count  <= push_en ? CNT_W'(1) : '0;
        overflowed <= 1'b0;
      end else if (push_en) begin
        if (store_full) begin
          overflowed <= 1'b1;
        end else begin
          bit_count <= CNT_W'(bit_count + CNT_W'(1));
        end
      end
      if (in_acc && locked && ws_edge) begin
        pend_push <= ~one_bit_delay;
      end
      if (state == ST_CHECK) begin
        err_mode <= chk_err;
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ws_edge) begin
      pend_bit <= din;
    end
    unique case (state)
      ST_CHECK: begin
        per  <= per_c;
        base <= right_aligned ? CNT_W'(per_c - CNT_W'(wb_eff)) : '0;
        j    <= '0;
        sub  <= '0;
        if (overflowed) begin
          err_kind <= KIND_OVERFLOW;
        end else if (uneven) begin
          err_kind <= KIND_UNEVEN;
        end else begin
          err_kind <= KIND_SHORT;
        end
      end
      ST_READ: j <= POS_W'(j + POS_W'(1));
      ST_EMIT: begin
        if (emit_go && !err_mode && !last_sub) begin
          sub  <= sub + 2'd1;
          base <= CNT_W'(base + per);
          j    <= '0;
        end
      end
      default: ;
    endcase
    if (emit_go) begin
      out_kind  <= err_mode ? err_kind : chan_kind;
      out_sub   <= err_mode ? 2'd0 : sub;
      out_value <= err_mode ? 64'd0 : word;
      out_last  <= err_mode | last_sub;
    end
  end

  assign m_tdata = out_value;
  assign m_tuser = {out_sub, out_kind};
  assign m_tlast = out_last;

  i2sd_frame_mem #(
    .DEPTH  (MAX_FRAME_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (push_data),
    .re    (wctl.issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  i2sd_word_unit u_word (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (wctl),
    .rd_bit       (mem_rdata),
    .wb_eff       (wb_eff),
    .signed_words (signed_words),
    .word         (word)
  );

endmodule
`default_nettype wire

FILE: design/i2sd_checker.sv
`default_nettype none
`include "i2s_pcm_frame_deserializer_unit_assert.svh"
module i2sd_checker
  import i2sd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [4:0]  m_tuser,
  input wire logic        m_tlast
);

  `I2SD_ASSERT_RST(a_reset_clears_out, clk, rst |=> !m_tvalid, "output valid after reset")
  `I2SD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transfer changed")
  `I2SD_ASSERT(a_err_shape, clk, rst, m_tvalid && (m_tuser[2:0] == KIND_UNEVEN || m_tuser[2:0] == KIND_SHORT || m_tuser[2:0] == KIND_OVERFLOW) |-> m_tlast && m_tuser[4:3] == 2'd0 && m_tdata == 64'd0, "malformed error result")
  `I2SD_ASSERT(a_kind_range, clk, rst, m_tvalid |-> m_tuser[2:0] <= KIND_OVERFLOW, "unknown result kind")
  `I2SD_ASSERT(a_busy_after_transfer, clk, rst, $fell(s_tready) |-> $past(s_tvalid && s_tready), "ready dropped without transfer")

endmodule

bind i2s_pcm_frame_deserializer_unit i2sd_checker u_i2sd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import i2sd_pkg::*;

  localparam int STORE_BITS = MAX_FRAME_BITS_DEF;
  localparam logic [1:0] LAYOUT_FOUR = 2'd2;
  localparam logic [1:0] LAYOUT_SPARE = 2'd3;
  localparam int FILL_ZEROS = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_RANDOM = 2;

  typedef struct {
    kind_t       kind;
    logic [1:0]  subframe;
    logic [63:0] word;
    logic        last;
  } audio_word_t;

  class frame_scoreboard;
    audio_word_t expected_words[$];
    bit          frame_bits[STORE_BITS];
    int unsigned bit_count;
    bit          prev_ws;
    bit          locked;
    bit          overflowed;
    bit [1:0]    layout;
    bit [6:0]    word_bits;
    bit          right_aligned;
    bit          lsb_first;
    bit          ws_inverted;
    bit          signed_words;
    bit          one_bit_delay;
    int          errors;

    function new();
      prev_ws = 1;
      layout = LAYOUT_ONE;
      word_bits = 16;
      signed_words = 1;
      one_bit_delay = 1;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_FRAME_LAYOUT:  layout = v[1:0];
        REG_WORD_BITS:     word_bits = v[6:0];
        REG_RIGHT_ALIGNED: right_aligned = v[0];
        REG_LSB_FIRST:     lsb_first = v[0];
        REG_WS_INVERTED:   ws_inverted = v[0];
        REG_SIGNED_WORDS:  signed_words = v[0];
        REG_ONE_BIT_DELAY: one_bit_delay = v[0];
        default: ;
      endcase
    endfunction

    function bit [31:0] reg_value(reg_idx_t idx);
      bit [31:0] v;
      v = '0;
      case (idx)
        REG_FRAME_LAYOUT:  v[1:0] = layout;
        REG_WORD_BITS:     v[6:0] = word_bits;
        REG_RIGHT_ALIGNED: v[0] = right_aligned;
        REG_LSB_FIRST:     v[0] = lsb_first;
        REG_WS_INVERTED:   v[0] = ws_inverted;
        REG_SIGNED_WORDS:  v[0] = signed_words;
        REG_ONE_BIT_DELAY: v[0] = one_bit_delay;
        default: ;
      endcase
      return v;
    endfunction

    function void push_bit(bit d);
      if (bit_count < STORE_BITS) begin
        frame_bits[bit_count] = d;
        bit_count++;
      end else begin
        overflowed = 1;
      end
    endfunction

    function void close_frame();
      int unsigned parts;
      int unsigned wb;
      int unsigned per;
      int unsigned off;
      int unsigned base;
      audio_word_t w;
      parts = (layout == LAYOUT_ONE) ? 1 : ((layout == LAYOUT_TWO) ? 2 : 4);
      wb = (word_bits == 0) ? 1 : ((word_bits > WORD_W) ? WORD_W : word_bits);
      w.subframe = '0;
      w.word = '0;
      w.last = 1;
      if (overflowed) begin
        w.kind = KIND_OVERFLOW;
        expected_words.push_back(w);
      end else if (bit_count % parts != 0) begin
        w.kind = KIND_UNEVEN;
        expected_words.push_back(w);
      end else if (bit_count / parts < wb) begin
        w.kind = KIND_SHORT;
        expected_words.push_back(w);
      end else begin
        per = bit_count / parts;
        off = right_aligned ? per - wb : 0;
        for (int i = 0; i < parts; i++) begin
          base = i * per + off;
          w.word = '0;
          for (int j = 0; j < wb; j++) begin
            w.word[lsb_first ? j : wb - 1 - j] = frame_bits[base + j];
          end
          if (signed_words && wb < WORD_W && w.word[wb - 1]) begin
            w.word |= ~64'd0 << wb;
          end
          w.kind = (i[0] == !ws_inverted) ? KIND_CH_ONE : KIND_CH_TWO;
          w.subframe = i[1:0];
          w.last = (i == parts - 1);
          expected_words.push_back(w);
        end
      end
      bit_count = 0;
      overflowed = 0;
    endfunction

    function void decode_bit(bit d, bit ws);
      bit rising;
      rising = ws && !prev_ws;
      prev_ws = ws;
      if (!locked) begin
        if (rising) begin
          locked = 1;
          bit_count = 0;
          overflowed = 0;
          if (!one_bit_delay) begin
            push_bit(d);
          end
        end
      end else if (rising && one_bit_delay) begin
        push_bit(d);
        close_frame();
      end else if (rising) begin
        close_frame();
        push_bit(d);
      end else begin
        push_bit(d);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [2:0] kind, logic [1:0] sub, logic [63:0] word, logic last);
      audio_word_t e;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result kind %0d subframe %0d", kind, sub));
      end else begin
        e = expected_words.pop_front();
        if (kind !== e.kind) begin
          report($sformatf("kind %0d, expected %0d", kind, e.kind));
        end
        if (sub !== e.subframe) begin
          report($sformatf("subframe %0d, expected %0d", sub, e.subframe));
        end
        if (word !== e.word) begin
          report($sformatf("word %h, expected %h", word, e.word));
        end
        if (last !== e.last) begin
          report($sformatf("last %b, expected %b", last, e.last));
        end
      end
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;  // [0] data_bit
  logic                  s_tuser;  // [0] ws_bit
  logic                  m_tvalid;
  logic                  m_tready;
  logic [63:0]           m_tdata;  // [63:0] word_value
  logic [4:0]            m_tuser;  // [2:0] kind, [4:3] subframe
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  frame_scoreboard sb = new();
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned locked_items;

  i2s_pcm_frame_deserializer_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.decode_bit(s_tdata[0], s_tuser);
      if (sb.locked) begin
        locked_items++;
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      sb.check_word(m_tuser[2:0], m_tuser[4:3], m_tdata, m_tlast);
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic apb_cycle(input bit wr, input reg_idx_t idx, input bit [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      sb.set_reg(idx, v);
    end else if (prdata !== sb.reg_value(idx)) begin
      sb.report($sformatf("register %s reads %h, expected %h", idx.name(), prdata,
                          sb.reg_value(idx)));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input bit [31:0] v);
    apb_cycle(1, idx, v);
    apb_cycle(0, idx, 0);
    psel <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  task automatic configure(input bit [1:0] lay, input bit [6:0] wb, input bit ra,
                           input bit lf, input bit wi, input bit sw, input bit obd);
    write_reg(REG_FRAME_LAYOUT, lay);
    write_reg(REG_WORD_BITS, wb);
    write_reg(REG_RIGHT_ALIGNED, ra);
    write_reg(REG_LSB_FIRST, lf);
    write_reg(REG_WS_INVERTED, wi);
    write_reg(REG_SIGNED_WORDS, sw);
    write_reg(REG_ONE_BIT_DELAY, obd);
  endtask

  task automatic send_bit(input bit d, input bit ws);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, d};
    s_tuser <= ws;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // ws rises on the first bit, stays high a while, then low until the next frame
  task automatic send_frame(input int unsigned n, input int fill);
    int unsigned high_bits;
    bit d;
    high_bits = $urandom_range(1, n - 1);
    for (int k = 0; k < n; k++) begin
      d = (fill == FILL_RANDOM) ? $urandom_range(0, 1) : (fill == FILL_ONES);
      send_bit(d, k < high_bits);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_section(input int unsigned budget);
    int unsigned start;
    int unsigned parts;
    int unsigned wb;
    int unsigned per;
    int unsigned n;
    int unsigned r;
    int fill;
    bit [1:0] lay;
    start = locked_items;
    while (locked_items - start < budget) begin
      drain();
      lay = $urandom_range(0, 3);
      parts = (lay == LAYOUT_ONE) ? 1 : ((lay == LAYOUT_TWO) ? 2 : 4);
      wb = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                      : $urandom_range(9, (parts > 2) ? 12 : 24);
      configure(lay, wb, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1));
      repeat ($urandom_range(3, 6)) begin
        r = $urandom_range(0, 99);
        per = wb + $urandom_range(0, 3);
        fill = ($urandom_range(0, 9) < 8) ? FILL_RANDOM : $urandom_range(FILL_ZEROS, FILL_ONES);
        if (r < 70) begin
          n = parts * per;
        end else if (r < 82 && parts > 1) begin
          n = parts * per + $urandom_range(1, parts - 1);
        end else if (r < 92) begin
          n = parts * $urandom_range(0, wb - 1);
        end else begin
          n = 0;
          repeat ($urandom_range(1, 6)) send_bit($urandom_range(0, 1), $urandom_range(0, 1));
        end
        if (n != 0) begin
          send_frame((n < 2) ? 2 : n, fill);
        end
      end
    end
  endtask

  initial begin
    rst <= 1;
    s_tvalid <= 0;
    s_tdata <= '0;
    s_tuser <= 0;
    m_tready <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    tx_idle_pct = 34;
    rx_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // register defaults after reset
    for (int i = REG_FRAME_LAYOUT; i <= REG_ONE_BIT_DELAY; i++) begin
      apb_cycle(0, reg_idx_t'(i), 0);
    end
    psel <= 0;
    penable <= 0;
    @(posedge clk);

    // lock without delay, then good, uneven and short frames
    configure(LAYOUT_TWO, 2, 0, 0, 0, 1, 0);
    send_bit(1, 1);
    send_bit(0, 1);
    send_bit(1, 0);
    send_frame(4, FILL_ONES);
    send_frame(4, FILL_ZEROS);
    send_frame(5, FILL_RANDOM);
    send_frame(2, FILL_RANDOM);
    send_frame(2, FILL_RANDOM);
    drain();
    configure(LAYOUT_ONE, 3, 1, 1, 1, 0, 1);
    send_frame(4, FILL_ONES);
    send_frame(2, FILL_ZEROS);

    random_section(105);
    tx_idle_pct = 79;
    rx_idle_pct = 34;
    random_section(105);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_section(100);

    // layout code three and a zero word width
    drain();
    configure(LAYOUT_SPARE, 0, 0, 0, 0, 1, 1);
    send_frame(8, FILL_RANDOM);
    send_frame(4, FILL_ONES);
    send_frame(6, FILL_RANDOM);
    send_frame(2, FILL_RANDOM);

    // full store with 64-bit words
    drain();
    configure(LAYOUT_FOUR, 64, 0, 0, 1, 1, 0);
    send_frame(256, FILL_RANDOM);
    send_frame(70, FILL_RANDOM);

    // oversized word width, then store overflow
    drain();
    configure(LAYOUT_ONE, 127, 1, 0, 0, 1, 1);
    send_frame(260, FILL_RANDOM);
    send_frame(2, FILL_ONES);
    send_frame(2, FILL_ZEROS);

    drain();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
